FILE: sv/bdks_pkg.sv
// Shared types, codes and constants for the bucket directory key search block.
`default_nettype none
package bdks_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int DIR_BITS_DEF    = 10;
  localparam int KEY_W           = 64;
  localparam int POS_W           = 12;
  localparam int LIMIT_W         = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEAL   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_ORDER     = 3'd3,
    ST_PHASE     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [POS_W-1:0] position;
  } out_t;

  typedef enum logic [1:0] {
    KR_J   = 2'd0,
    KR_MID = 2'd1,
    KR_LO  = 2'd2
  } krd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC,
    S_BLD_RD, S_BLD_EVAL, S_BLD_FILL, S_TAIL,
    S_Q_A, S_Q_B, S_Q_C, S_Q_CHK,
    S_B_RD, S_B_EVAL, S_B_CHK, S_F_RD, S_F_EVAL,
    S_L_RD, S_L_EVAL
  } state_t;

  typedef struct packed {
    logic     load;
    logic     append;
    logic     bld_init;
    logic     bld_bkt;
    logic     dir_wr_j;
    logic     j_inc;
    logic     dir_wr_cnt;
    logic     set_sealed;
    logic     dir_rd_hi;
    logic     lo_from_dir;
    logic     hi_from_dir;
    krd_sel_t krd_sel;
    logic     bin_step;
    logic     lin_step;
    logic     res;
    status_t  res_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sealed;
    logic full;
    logic order_bad;
    logic j_end;
    logic nb_le_bkt;
    logic tail_more;
    logic lo_lt_hi;
    logic lo_lt_end;
    logic lo1_lt_hi;
    logic binary;
    logic eq;
  } flags_t;

endpackage
`default_nettype wire

FILE: sv/bucket_directory_key_search.sv
// Top level: configuration register, controller and datapath of the key search block.
//
//  channel  | signals                         | transaction
//  ---------+---------------------------------+------------------------------
//  item     | start, busy, item               | start high while busy low
//  result   | done, result                    | done high for one cycle
//  config   | psel penable pwrite paddr pwdata| APB write, pready always high
//
// Append and error items are answered from the execute state.
// A seal reads the keys in turn and writes one directory entry per bucket plus
// the count entry; each key passes through the read, evaluate and fill states.
// A query reads the bucket bounds from the directory (registered reads) and stops
// for an empty bucket; else it scans the keys, or binary-searches above the limit.
// Reset clears the count, the sealed flag and the limit (4096); no clearing pass.
// Results cannot be stalled; busy holds off the next item.
`default_nettype none
module bucket_directory_key_search import bdks_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int DIR_BITS    = DIR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         item,
  output logic             done,
  output out_t             result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  logic [LIMIT_W-1:0] limit;
  cmd_t               cmd;
  flags_t             flags;
  logic               start_ok;

  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? 32'(limit) : 32'd0;
  assign start_ok = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  bdks_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  bdks_dp #(.STORE_DEPTH(STORE_DEPTH), .DIR_BITS(DIR_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .limit  (limit),
    .cmd    (cmd),
    .flags  (flags),
    .done   (done),
    .result (result)
  );
endmodule
`default_nettype wire

FILE: sv/bdks_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/bdks_ctrl.sv
// Controller state machine: sequences append, directory build and search.
`default_nettype none
module bdks_ctrl import bdks_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire flags_t flags,
  output cmd_t        cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.krd_sel = KR_J;
    cmd.res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (flags.op)
          OP_APPEND: begin
            cmd.res = 1'b1;
            state_next = S_IDLE;
            if (flags.sealed) cmd.res_status = ST_PHASE;
            else if (flags.full) cmd.res_status = ST_FULL;
            else if (flags.order_bad) cmd.res_status = ST_ORDER;
            else cmd.append = 1'b1;
          end
          OP_SEAL: begin
            if (flags.sealed) begin
              cmd.res = 1'b1;
              cmd.res_status = ST_PHASE;
              state_next = S_IDLE;
            end else begin
              cmd.bld_init = 1'b1;
              state_next = S_BLD_RD;
            end
          end
          OP_QUERY: begin
            if (!flags.sealed) begin
              cmd.res = 1'b1;
              cmd.res_status = ST_PHASE;
              state_next = S_IDLE;
            end else begin
              state_next = S_Q_A;
            end
          end
          default: begin
            cmd.res = 1'b1;
            cmd.res_status = ST_PHASE;
            state_next = S_IDLE;
          end
        endcase
      end
      S_BLD_RD: begin
        cmd.krd_sel = KR_J;
        state_next = flags.j_end ? S_TAIL : S_BLD_EVAL;
      end
      S_BLD_EVAL: begin
        cmd.bld_bkt = 1'b1;
        state_next = S_BLD_FILL;
      end
      S_BLD_FILL: begin
        // point every bucket up to this key's bucket at this key
        if (flags.nb_le_bkt) begin
          cmd.dir_wr_j = 1'b1;
        end else begin
          cmd.j_inc = 1'b1;
          state_next = S_BLD_RD;
        end
      end
      S_TAIL: begin
        if (flags.tail_more) begin
          cmd.dir_wr_cnt = 1'b1;
        end else begin
          cmd.set_sealed = 1'b1;
          cmd.res = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_Q_A: begin
        state_next = S_Q_B;
      end
      S_Q_B: begin
        cmd.dir_rd_hi = 1'b1;
        cmd.lo_from_dir = 1'b1;
        state_next = S_Q_C;
      end
      S_Q_C: begin
        cmd.hi_from_dir = 1'b1;
        state_next = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (!flags.lo_lt_hi) begin
          cmd.res = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else if (flags.binary) begin
          state_next = S_B_RD;
        end else begin
          state_next = S_L_RD;
        end
      end
      S_B_RD: begin
        cmd.krd_sel = KR_MID;
        state_next = S_B_EVAL;
      end
      S_B_EVAL: begin
        cmd.bin_step = 1'b1;
        state_next = S_B_CHK;
      end
      S_B_CHK: begin
        if (flags.lo_lt_hi) begin
          state_next = S_B_RD;
        end else if (flags.lo_lt_end) begin
          state_next = S_F_RD;
        end else begin
          cmd.res = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      S_F_RD: begin
        cmd.krd_sel = KR_LO;
        state_next = S_F_EVAL;
      end
      S_F_EVAL: begin
        cmd.res = 1'b1;
        cmd.res_status = flags.eq ? ST_OK : ST_NOT_FOUND;
        state_next = S_IDLE;
      end
      S_L_RD: begin
        cmd.krd_sel = KR_LO;
        state_next = S_L_EVAL;
      end
      S_L_EVAL: begin
        if (flags.eq) begin
          cmd.res = 1'b1;
          state_next = S_IDLE;
        end else if (flags.lo1_lt_hi) begin
          cmd.lin_step = 1'b1;
          state_next = S_L_RD;
        end else begin
          cmd.res = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/bdks_dp.sv
// Datapath: key store, directory memory, counters, search bounds and result register.
`default_nettype none
module bdks_dp import bdks_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int DIR_BITS    = DIR_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire in_t                item,
  input  wire logic [LIMIT_W-1:0] limit,
  input  wire cmd_t               cmd,
  output flags_t                  flags,
  output logic                    done,
  output out_t                    result
);
  localparam int CW      = $clog2(STORE_DEPTH + 1);
  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int NBKT    = 1 << DIR_BITS;
  localparam int DDEPTH  = NBKT + 1;
  localparam int DAW     = $clog2(DDEPTH);
  localparam int NBW     = DIR_BITS + 2;

  logic [1:0]              op_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] prev_key;
  logic [CW-1:0]           count;
  logic                    sealed;
  logic [CW-1:0]           j, lo, hi, end_idx;
  logic [NBW-1:0]          nb;
  logic [DIR_BITS-1:0]     bkt;
  logic [DIR_BITS-1:0]     q_bkt;
  logic [DIR_BITS-1:0]     r_bkt;
  logic [CW-1:0]           mid;
  logic [AW-1:0]           k_raddr;
  logic signed [KEY_W-1:0] k_rdata;
  logic [DAW-1:0]          d_raddr, d_waddr;
  logic [CW-1:0]           d_wdata, d_rdata;
  logic                    d_we;
  logic [KEY_W-1:0]        flip_q, flip_r;

  assign flip_q = key_q ^ {1'b1, {(KEY_W-1){1'b0}}};
  assign flip_r = k_rdata ^ {1'b1, {(KEY_W-1){1'b0}}};
  assign q_bkt  = flip_q[KEY_W-1 -: DIR_BITS];
  assign r_bkt  = flip_r[KEY_W-1 -: DIR_BITS];
  assign mid    = lo + ((hi - lo) >> 1);

  always_comb begin
    case (cmd.krd_sel)
      KR_MID:  k_raddr = mid[AW-1:0];
      KR_LO:   k_raddr = lo[AW-1:0];
      default: k_raddr = j[AW-1:0];
    endcase
  end

  assign d_raddr = cmd.dir_rd_hi ? (DAW'(q_bkt) + DAW'(1)) : DAW'(q_bkt);
  assign d_we    = cmd.dir_wr_j | cmd.dir_wr_cnt;
  assign d_waddr = nb[DAW-1:0];
  assign d_wdata = cmd.dir_wr_cnt ? count : j;

  bdks_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_keys (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[AW-1:0]),
    .wdata (key_q),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  bdks_ram #(.WIDTH(CW), .DEPTH(DDEPTH)) u_dir (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sealed <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= cmd.res;
      if (cmd.append) count <= count + CW'(1);
      if (cmd.set_sealed) sealed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= item.op;
      key_q <= item.key;
    end
    if (cmd.append) prev_key <= key_q;
    if (cmd.bld_init) begin
      j  <= '0;
      nb <= '0;
    end
    if (cmd.bld_bkt) bkt <= r_bkt;
    if (cmd.j_inc) j <= j + CW'(1);
    if (d_we) nb <= nb + NBW'(1);
    if (cmd.lo_from_dir) lo <= d_rdata;
    if (cmd.hi_from_dir) begin
      hi      <= d_rdata;
      end_idx <= d_rdata;
    end
    if (cmd.bin_step) begin
      if (k_rdata < key_q) lo <= mid + CW'(1);
      else hi <= mid;
    end
    if (cmd.lin_step) lo <= lo + CW'(1);
    if (cmd.res) begin
      result.status   <= cmd.res_status;
      result.position <= (cmd.res_status == ST_OK && op_q == OP_QUERY) ? POS_W'(lo) : '0;
    end
  end

  always_comb begin
    flags.op        = op_t'(op_q);
    flags.sealed    = sealed;
    flags.full      = (count == CW'(STORE_DEPTH));
    flags.order_bad = (count != '0) && (key_q < prev_key);
    flags.j_end     = (j == count);
    flags.nb_le_bkt = (nb <= NBW'(bkt));
    flags.tail_more = (nb <= NBW'(NBKT));
    flags.lo_lt_hi  = (lo < hi);
    flags.lo_lt_end = (lo < end_idx);
    flags.lo1_lt_hi = ((lo + CW'(1)) < hi);
    flags.binary    = (32'(hi - lo) > 32'(limit));
    flags.eq        = (k_rdata == key_q);
  end
endmodule
`default_nettype wire

FILE: sv/bdks_checker.sv
// Port-level checker for the key search block, bound to the top level.
`default_nettype none
module bdks_checker import bdks_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire out_t result
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status <= 3'd4) else $error("undefined status code");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.position == '0)
    else $error("position not zero on failure");
endmodule

bind bucket_directory_key_search bdks_checker u_bdks_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

FILE: test/bucket_directory_key_search_tb.sv
// Self-checking testbench for the bucket directory key search block.
`timescale 1ns / 1ps
module bucket_directory_key_search_tb;
  import bdks_pkg::*;

  localparam int DEPTH   = 4096;
  localparam int NBKT    = 1024;
  localparam int MAX_CYC = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t item = '0;
  logic done;
  out_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bucket_directory_key_search uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [63:0] keys_held [DEPTH];
  int unsigned first_idx [NBKT+1];
  int unsigned held_count;
  bit is_sealed;
  logic signed [63:0] last_key;
  int unsigned scan_limit;

  in_t  pending_items[$];
  out_t expected_results[$];
  int errors = 0;
  int cycles = 0;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned bucket_of(input logic [63:0] k);
    logic [63:0] f;
    f = k ^ 64'h8000_0000_0000_0000;
    return f[63:54];
  endfunction

  function automatic out_t predict_search(input in_t it);
    out_t r;
    int unsigned b, lo, hi, fin, mid;
    logic signed [63:0] tgt;
    bit hit;
    r = '0;
    hit = 0;
    tgt = it.key;
    case (op_t'(it.op))
      OP_APPEND: begin
        if (is_sealed) r.status = ST_PHASE;
        else if (held_count >= DEPTH) r.status = ST_FULL;
        else if (held_count > 0 && tgt < last_key) r.status = ST_ORDER;
        else begin
          keys_held[held_count] = it.key;
          held_count++;
          last_key = tgt;
        end
      end
      OP_SEAL: begin
        if (is_sealed) r.status = ST_PHASE;
        else begin
          for (int i = 0; i <= NBKT; i++) first_idx[i] = 'hFFFF_FFFF;
          for (int j = held_count - 1; j >= 0; j--) first_idx[bucket_of(keys_held[j])] = j;
          first_idx[NBKT] = held_count;
          for (int i = NBKT; i > 0; i--)
            if (first_idx[i-1] == 'hFFFF_FFFF) first_idx[i-1] = first_idx[i];
          is_sealed = 1;
        end
      end
      OP_QUERY: begin
        if (!is_sealed) r.status = ST_PHASE;
        else begin
          if (held_count > 0) begin
            b = bucket_of(it.key);
            lo = first_idx[b];
            hi = first_idx[b+1];
            if (hi > held_count) hi = held_count;
            if (lo < hi) begin
              if (hi - lo > scan_limit) begin
                fin = hi;
                while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if ($signed(keys_held[mid]) < tgt) lo = mid + 1;
                  else hi = mid;
                end
                if (lo < fin && keys_held[lo] == it.key) begin
                  hit = 1;
                  r.position = lo[11:0];
                end
              end else begin
                for (int i = lo; i < hi && !hit; i++)
                  if (keys_held[i] == it.key) begin
                    hit = 1;
                    r.position = i[11:0];
                  end
              end
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
        end
      end
      default: r.status = ST_PHASE;
    endcase
    return r;
  endfunction

  // driver: bursts with random gaps; offer only while idle so the next edge takes it
  int gap = 0, burst = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0 && !busy) begin
      item <= pending_items.pop_front();
      start <= 1'b1;
      if (burst == 0) begin
        burst <= $urandom_range(1, 12);
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst <= burst - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on acceptance, check on strobe
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) expected_results.push_back(predict_search(item));
      if (done) begin
        if (expected_results.size() == 0) report("result with nothing expected");
        else begin
          out_t e;
          e = expected_results.pop_front();
          if (result.status !== e.status)
            report($sformatf("status %0d, expected %0d", result.status, e.status));
          if (result.position !== e.position)
            report($sformatf("position %0d, expected %0d", result.position, e.position));
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    scan_limit = v & 32'h1FFF;
  endtask

  task automatic push(input op_t o, input logic [63:0] k);
    in_t t;
    t.op = o;
    t.key = k;
    pending_items.push_back(t);
  endtask

  initial begin
    held_count = 0; is_sealed = 0; last_key = '0; scan_limit = 4096;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: wrong phase, extremes, order, duplicates, empty bucket
    push(OP_QUERY, 64'h0);
    push(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    push(OP_APPEND, 64'h8000_0000_0000_0000);
    push(OP_APPEND, 64'h8000_0000_0000_0000);
    push(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF);
    push(OP_APPEND, 64'h8000_0000_0000_0005);
    push(OP_APPEND, 64'h0);
    push(OP_APPEND, 64'h0);
    push(OP_APPEND, 64'h0000_0000_0000_0007);
    push(OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF);
    push(OP_SEAL, '0);
    push(OP_SEAL, '0);
    push(OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF);
    push(OP_QUERY, 64'h8000_0000_0000_0000);
    push(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
    push(OP_QUERY, 64'h0);
    push(OP_QUERY, 64'h7);
    push(OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
    push(OP_QUERY, 64'h1234_5678_9ABC_DEF0);
    push(OP_QUERY, 64'h1);
    push(OP_NONE, '0);
    wait_idle();
    // new phases need a reset-free way back to loading: none exists, so
    // sweep the limit over the sealed store
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_limit(0);
        1: write_limit(1);
        2: write_limit(8191);
        default: write_limit($urandom_range(2, 4096));
      endcase
      push(OP_QUERY, 64'h0);
      push(OP_QUERY, 64'h8000_0000_0000_0000);
      for (int i = 0; i < 90; i++) push(op_t'($urandom_range(0, 3)), {$urandom, $urandom});
      wait_idle();
    end
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: bucket_directory_key_search.f
sv/bdks_pkg.sv
sv/bdks_ram.sv
sv/bdks_ctrl.sv
sv/bdks_dp.sv
sv/bucket_directory_key_search.sv
sv/bdks_checker.sv
test/bucket_directory_key_search_tb.sv
